// ===== sv/lsss_pkg.sv =====
// Shared constants, codes and types of the light show segment sequencer.
package lsss_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = SEG_W + 1;
  localparam int SEGS_W       = 5;
  localparam int SEC_W        = 16;
  localparam int T_W          = 16;
  localparam int F_W          = 8;
  localparam int MS_W         = 32;
  localparam int MSK_W        = 10;
  localparam int LIM_W        = SEC_W + MSK_W;
  localparam int PROD_W       = F_W + T_W;
  localparam int OP_W         = 3;
  localparam int PH_W         = 2;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_STEPS    = F_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 24;

  localparam logic [MSK_W-1:0] MS_PER_SEC = MSK_W'(1000);

  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_TRIG  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

  localparam logic [PH_W-1:0] PH_NONE     = 2'd0;
  localparam logic [PH_W-1:0] PH_FADE_OUT = 2'd1;
  localparam logic [PH_W-1:0] PH_ACTIVE   = 2'd2;
  localparam logic [PH_W-1:0] PH_FADE_IN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS   = 2'd2;

  localparam logic [T_W-1:0]    TRANSITION_RST = 16'd500;
  localparam logic [F_W-1:0]    FULL_RST       = 8'd255;
  localparam logic [SEGS_W-1:0] SEGMENTS_RST   = 5'd0;
  localparam logic [F_W-1:0]    LEVEL_RST      = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic look;
    logic exec;
    logic mul;
    logic div_step;
    logic div_last;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic i_stop;
    logic i_start;
    logic s_stop;
    logic s_start;
    logic r_int;
    logic r_main;
  } flags_t;

endpackage

// ===== sv/lsss_ctrl.sv =====
// Control state machine of the segment sequencer: sequences lookup, update, fade divide, emit.
module lsss_ctrl
  import lsss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lsss_dp.sv =====
// Datapath of the segment sequencer: settings, sequence state, duration table, fade divider, result register.
module lsss_dp
  import lsss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [OP_W-1:0]        in_operation,
  input  logic                   in_flash_interrupt,
  input  logic [MS_W-1:0]        in_interrupt_ms,
  input  logic                   in_flash_complete,
  input  logic [SEG_W-1:0]       in_slot,
  input  logic [SEC_W-1:0]       in_seconds,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  // settings
  logic [T_W-1:0]    trans_r;
  logic [F_W-1:0]    full_r;
  logic [SEGS_W-1:0] segs_r;

  // sequence state
  logic              run_r, run_nxt;
  logic [SEG_W-1:0]  cur_r, cur_nxt;
  logic [MS_W-1:0]   seg_el_r, seg_el_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [T_W-1:0]    fade_r, fade_nxt;
  logic [MS_W-1:0]   int_el_r, int_el_nxt;
  logic [MS_W-1:0]   int_lim_r, int_lim_nxt;
  logic              is_flash_r, is_flash_nxt;
  logic [F_W-1:0]    level_r, level_nxt;
  logic [MAX_SEGMENTS-1:0] loaded_r;
  logic [SEC_W-1:0]  seg_sec_r [MAX_SEGMENTS];

  // held beat
  logic [OP_W-1:0]   op_r;
  logic              flash_in_r;
  logic [MS_W-1:0]   int_ms_r;
  logic              flash_done_r;
  logic [SEG_W-1:0]  slot_r;
  logic [SEC_W-1:0]  secs_r;

  // work registers
  logic [LIM_W-1:0]  lim_r;
  flags_t            flags_r, flags_nxt;
  logic              need_div;
  logic [T_W-1:0]    opnd_r, opnd_nxt;
  logic [T_W-1:0]    rem_r;
  logic [F_W-1:0]    lo_r;
  logic [F_W-1:0]    quo_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [CNT_W-1:0]  seg_cnt;
  logic [CNT_W-1:0]  inc_idx;
  logic [SEG_W-1:0]  nxt_idx;
  logic              cur_valid;
  logic              nxt_valid;
  logic [LIM_W-1:0]  lim_calc;
  logic [PROD_W-1:0] prod;
  logic [T_W:0]      trial;
  logic [T_W:0]      trial_diff;
  logic              trial_ge;
  logic [F_W-1:0]    quo_nxt;

  assign seg_cnt   = (segs_r > SEGS_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : CNT_W'(segs_r);
  assign cur_valid = ({1'b0, cur_r} < seg_cnt) && loaded_r[cur_r];
  assign inc_idx   = {1'b0, cur_r} + 1'b1;
  assign nxt_idx   = (inc_idx >= seg_cnt) ? '0 : inc_idx[SEG_W-1:0];
  assign nxt_valid = ({1'b0, nxt_idx} < seg_cnt) && loaded_r[nxt_idx];

  assign lim_calc   = {{MSK_W{1'b0}}, seg_sec_r[cur_r]} * {{SEC_W{1'b0}}, MS_PER_SEC};
  assign prod       = {{T_W{1'b0}}, full_r} * {{F_W{1'b0}}, opnd_r};
  assign trial      = {rem_r, lo_r[F_W-1]};
  assign trial_diff = trial - {1'b0, trans_r};
  assign trial_ge   = (trial >= {1'b0, trans_r});
  assign quo_nxt    = {quo_r[F_W-2:0], trial_ge};

  always_comb begin
    run_nxt      = run_r;
    cur_nxt      = cur_r;
    seg_el_nxt   = seg_el_r;
    phase_nxt    = phase_r;
    fade_nxt     = fade_r;
    int_el_nxt   = int_el_r;
    int_lim_nxt  = int_lim_r;
    is_flash_nxt = is_flash_r;
    level_nxt    = level_r;
    flags_nxt    = '0;
    need_div     = 1'b0;
    opnd_nxt     = opnd_r;
    case (op_r)
      OP_TICK: begin
        if (run_r) begin
          if (phase_r inside {PH_FADE_OUT, PH_FADE_IN}) begin
            fade_nxt = (fade_r == '1) ? fade_r : fade_r + 1'b1;
          end else if (phase_r == PH_ACTIVE && !is_flash_r) begin
            int_el_nxt = (int_el_r == '1) ? int_el_r : int_el_r + 1'b1;
          end else if (phase_r == PH_NONE && cur_valid) begin
            seg_el_nxt = (seg_el_r == '1) ? seg_el_r : seg_el_r + 1'b1;
          end

          if (phase_r == PH_FADE_OUT) begin
            if (fade_nxt >= trans_r) begin
              phase_nxt         = PH_ACTIVE;
              int_el_nxt        = '0;
              flags_nxt.i_start = 1'b1;
              level_nxt         = full_r;
            end else begin
              need_div = 1'b1;
              opnd_nxt = trans_r - fade_nxt;
            end
          end else if (phase_r == PH_FADE_IN) begin
            if (fade_nxt >= trans_r) begin
              phase_nxt        = PH_NONE;
              flags_nxt.i_stop = 1'b1;
              level_nxt        = full_r;
            end else begin
              need_div = 1'b1;
              opnd_nxt = fade_nxt;
            end
          end

          if (phase_nxt == PH_ACTIVE) begin
            flags_nxt.r_int = 1'b1;
            if (is_flash_r) begin
              flags_nxt.r_main = 1'b1;
              if (flash_done_r) begin
                phase_nxt = PH_NONE;
              end
            end else if (int_el_nxt >= int_lim_r) begin
              phase_nxt = PH_FADE_IN;
              fade_nxt  = '0;
            end
          end else if (phase_nxt == PH_NONE && cur_valid) begin
            flags_nxt.r_main = 1'b1;
            if (seg_el_nxt >= {{(MS_W - LIM_W){1'b0}}, lim_r}) begin
              flags_nxt.s_stop  = 1'b1;
              cur_nxt           = nxt_idx;
              seg_el_nxt        = '0;
              flags_nxt.s_start = nxt_valid;
            end
          end
        end
      end
      OP_START: begin
        if (seg_cnt != '0 && loaded_r[0]) begin
          cur_nxt           = '0;
          seg_el_nxt        = '0;
          run_nxt           = 1'b1;
          flags_nxt.s_start = 1'b1;
        end
      end
      OP_STOP: begin
        flags_nxt.s_stop = run_r && cur_valid;
        run_nxt          = 1'b0;
      end
      OP_TRIG: begin
        if (phase_r == PH_NONE) begin
          is_flash_nxt = flash_in_r;
          if (flash_in_r) begin
            phase_nxt         = PH_ACTIVE;
            int_el_nxt        = '0;
            flags_nxt.i_start = 1'b1;
          end else begin
            phase_nxt   = PH_FADE_OUT;
            fade_nxt    = '0;
            int_lim_nxt = int_ms_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r    <= TRANSITION_RST;
      full_r     <= FULL_RST;
      segs_r     <= SEGMENTS_RST;
      run_r      <= 1'b0;
      cur_r      <= '0;
      seg_el_r   <= '0;
      phase_r    <= PH_NONE;
      fade_r     <= '0;
      int_el_r   <= '0;
      int_lim_r  <= '0;
      is_flash_r <= 1'b0;
      level_r    <= LEVEL_RST;
      loaded_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRANSITION: trans_r <= cfg_wdata[T_W-1:0];
          REG_FULL:       full_r  <= cfg_wdata[F_W-1:0];
          REG_SEGMENTS:   segs_r  <= cfg_wdata[SEGS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        run_r      <= run_nxt;
        cur_r      <= cur_nxt;
        seg_el_r   <= seg_el_nxt;
        phase_r    <= phase_nxt;
        fade_r     <= fade_nxt;
        int_el_r   <= int_el_nxt;
        int_lim_r  <= int_lim_nxt;
        is_flash_r <= is_flash_nxt;
        level_r    <= level_nxt;
        if (op_r == OP_LOAD) begin
          loaded_r[slot_r] <= 1'b1;
        end
      end else if (cmd.div_last) begin
        level_r <= quo_nxt;
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r         <= in_operation;
      flash_in_r   <= in_flash_interrupt;
      int_ms_r     <= in_interrupt_ms;
      flash_done_r <= in_flash_complete;
      slot_r       <= in_slot;
      secs_r       <= in_seconds;
    end
    if (cmd.exec && op_r == OP_LOAD) begin
      seg_sec_r[slot_r] <= secs_r;
    end
    if (cmd.look) begin
      lim_r <= lim_calc;
    end
    if (cmd.exec) begin
      flags_r <= flags_nxt;
      opnd_r  <= opnd_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:F_W];
      lo_r  <= prod[F_W-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_diff[T_W-1:0] : trial[T_W-1:0];
      lo_r  <= {lo_r[F_W-2:0], 1'b0};
      quo_r <= quo_nxt;
    end
    if (cmd.emit) begin
      out_tdata_r <= {3'b000, flags_r, level_r, phase_r, cur_r, run_r};
    end
  end

  assign sts.need_div = need_div;
  assign sts.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;

endmodule

// ===== sv/light_show_segment_sequencer.sv =====
// Top level of the light show segment sequencer.
// A result beat is registered after its input beat passes the lookup, update and emit states; a fade tick
// that ends mid-fade adds a multiply and 8 restoring divide steps for the brightness.
// One input beat is in work at a time, and emit waits while the previous result beat is not yet taken.
// Reset: synchronous on rst_n low; settings return to 500 ms, 255, 0 segments; no segment is loaded.
module light_show_segment_sequencer
  import lsss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // flash_interrupt, interrupt_ms, flash_complete, slot, seconds, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // running, segment_index, phase, brightness, render_main, render_interrupt,
  // segment_started, segment_stopped, interrupt_started, interrupt_stopped, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  lsss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsss_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_tuser),
    .in_flash_interrupt (in_tdata[0]),
    .in_interrupt_ms    (in_tdata[32:1]),
    .in_flash_complete  (in_tdata[33]),
    .in_slot            (in_tdata[37:34]),
    .in_seconds         (in_tdata[53:38]),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input beat taken while previous beat in work");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.look, cmd.exec, cmd.mul, cmd.div_step, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result beat overwritten before taken");

  a_last_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> cmd.div_step)
    else $error("divide finish outside a divide step");

endmodule

// ===== bench/tb_light_show_segment_sequencer.sv =====
// Self-checking bench for the light show segment sequencer: stream driver, monitor, predictor.
module tb_light_show_segment_sequencer;
  import lsss_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic [OP_W-1:0] op;
    logic            flash;
    logic [31:0]     ms;
    logic            done;
    logic [3:0]      slot;
    logic [15:0]     secs;
  } beat_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       int_stopped;
    logic       int_started;
    logic       seg_stopped;
    logic       seg_started;
    logic       render_int;
    logic       render_main;
    logic [7:0] brightness;
    logic [1:0] phase;
    logic [3:0] seg_index;
    logic       running;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  light_show_segment_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  logic [15:0] cfg_fade_len = TRANSITION_RST;
  logic [7:0]  cfg_full     = FULL_RST;
  logic [4:0]  cfg_segments = SEGMENTS_RST;

  logic        seq_running  = 1'b0;
  logic [3:0]  seq_index    = '0;
  logic [31:0] seg_elapsed  = '0;
  logic [1:0]  seq_phase    = PH_NONE;
  logic [15:0] fade_elapsed = '0;
  logic [31:0] irq_elapsed  = '0;
  logic [31:0] irq_limit    = '0;
  logic        irq_flash    = 1'b0;
  logic [7:0]  seq_level    = LEVEL_RST;
  logic [15:0] slot_secs   [MAX_SEGMENTS];
  logic        slot_loaded [MAX_SEGMENTS];

  beat_t   pending_beats[$];
  status_t expected_status[$];
  beat_t   beat_on_bus;
  status_t got;
  status_t want;
  int unsigned     in_gap = 0;
  bit              in_burst = 1'b0;
  int unsigned     out_stall = 0;
  int unsigned     out_draw;
  bit              out_burst = 1'b0;
  int unsigned     mismatches = 0;
  int unsigned     beats_checked = 0;
  longint unsigned cycle_count = 0;

  function automatic logic [4:0] active_slots();
    return (cfg_segments > 5'(MAX_SEGMENTS)) ? 5'(MAX_SEGMENTS) : cfg_segments;
  endfunction

  function automatic logic slot_playable(logic [3:0] idx);
    return (5'(idx) < active_slots()) && slot_loaded[idx];
  endfunction

  function automatic status_t sequence_step(beat_t b);
    status_t r;
    logic [4:0] nxt;
    r = '0;
    if (b.op == OP_TICK && seq_running) begin
      if (seq_phase == PH_FADE_OUT || seq_phase == PH_FADE_IN) begin
        if (fade_elapsed != 16'hFFFF) fade_elapsed = fade_elapsed + 16'd1;
      end else if (seq_phase == PH_ACTIVE && !irq_flash) begin
        if (irq_elapsed != 32'hFFFF_FFFF) irq_elapsed = irq_elapsed + 32'd1;
      end else if (seq_phase == PH_NONE && slot_playable(seq_index)) begin
        if (seg_elapsed != 32'hFFFF_FFFF) seg_elapsed = seg_elapsed + 32'd1;
      end

      if (seq_phase == PH_FADE_OUT) begin
        if (fade_elapsed >= cfg_fade_len) begin
          seq_phase = PH_ACTIVE;
          irq_elapsed = '0;
          r.int_started = 1'b1;
          seq_level = cfg_full;
        end else begin
          seq_level = 8'((32'(cfg_full) * (32'(cfg_fade_len) - 32'(fade_elapsed)))
                         / 32'(cfg_fade_len));
        end
      end else if (seq_phase == PH_FADE_IN) begin
        if (fade_elapsed >= cfg_fade_len) begin
          seq_phase = PH_NONE;
          r.int_stopped = 1'b1;
          seq_level = cfg_full;
        end else begin
          seq_level = 8'((32'(cfg_full) * 32'(fade_elapsed)) / 32'(cfg_fade_len));
        end
      end

      if (seq_phase == PH_ACTIVE) begin
        r.render_int = 1'b1;
        if (irq_flash) begin
          r.render_main = 1'b1;
          if (b.done) seq_phase = PH_NONE;
        end else if (irq_elapsed >= irq_limit) begin
          seq_phase = PH_FADE_IN;
          fade_elapsed = '0;
        end
      end else if (seq_phase == PH_NONE && slot_playable(seq_index)) begin
        r.render_main = 1'b1;
        if (seg_elapsed >= 32'(slot_secs[seq_index]) * 32'd1000) begin
          nxt = 5'(seq_index) + 5'd1;
          r.seg_stopped = 1'b1;
          if (nxt >= active_slots()) nxt = '0;
          seq_index = nxt[3:0];
          seg_elapsed = '0;
          if (slot_playable(nxt[3:0])) r.seg_started = 1'b1;
        end
      end
    end else if (b.op == OP_START) begin
      if (active_slots() > 5'd0 && slot_loaded[0]) begin
        seq_index = '0;
        seg_elapsed = '0;
        seq_running = 1'b1;
        r.seg_started = 1'b1;
      end
    end else if (b.op == OP_STOP) begin
      if (seq_running && slot_playable(seq_index)) r.seg_stopped = 1'b1;
      seq_running = 1'b0;
    end else if (b.op == OP_TRIG) begin
      if (seq_phase == PH_NONE) begin
        irq_flash = b.flash;
        if (b.flash) begin
          seq_phase = PH_ACTIVE;
          irq_elapsed = '0;
          r.int_started = 1'b1;
        end else begin
          seq_phase = PH_FADE_OUT;
          fade_elapsed = '0;
          irq_limit = b.ms;
        end
      end
    end else if (b.op == OP_LOAD) begin
      slot_secs[b.slot] = b.secs;
      slot_loaded[b.slot] = 1'b1;
    end
    r.running = seq_running;
    r.seg_index = seq_index;
    r.phase = seq_phase;
    r.brightness = seq_level;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH beat %0d: %s", beats_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (seen !== want) report_mismatch($sformatf("%s want %0h got %0h", name, want, seen));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_status.push_back(sequence_step(beat_on_bus));
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          beat_on_bus = pending_beats.pop_front();
          in_tdata <= {2'b00, beat_on_bus.secs, beat_on_bus.slot, beat_on_bus.done,
                       beat_on_bus.ms, beat_on_bus.flash};
          in_tuser <= beat_on_bus.op;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap <= in_burst ? 0 : $urandom_range(0, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = status_t'(out_tdata);
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result beat %0h with nothing expected", out_tdata));
        end else begin
          want = expected_status[0];
          check_field("running", 32'(want.running), 32'(got.running));
          check_field("segment_index", 32'(want.seg_index), 32'(got.seg_index));
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("brightness", 32'(want.brightness), 32'(got.brightness));
          check_field("render_main", 32'(want.render_main), 32'(got.render_main));
          check_field("render_interrupt", 32'(want.render_int), 32'(got.render_int));
          check_field("segment_started", 32'(want.seg_started), 32'(got.seg_started));
          check_field("segment_stopped", 32'(want.seg_stopped), 32'(got.seg_stopped));
          check_field("interrupt_started", 32'(want.int_started), 32'(got.int_started));
          check_field("interrupt_stopped", 32'(want.int_stopped), 32'(got.int_stopped));
          check_field("pad", 32'(want.pad), 32'(got.pad));
          void'(expected_status.pop_front());
        end
        beats_checked++;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_draw = out_burst ? 0 : $urandom_range(0, 13);
        out_stall <= out_draw;
        out_tready <= (out_draw == 0);
      end else if (!out_tready) begin
        if (out_stall <= 1) begin
          out_tready <= 1'b1;
          out_stall <= 0;
        end else begin
          out_stall <= out_stall - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic beat_t noise_beat(logic [OP_W-1:0] op);
    beat_t b;
    b.op = op;
    b.flash = 1'($urandom);
    b.ms = $urandom;
    b.done = 1'($urandom);
    b.slot = 4'($urandom);
    b.secs = 16'($urandom);
    return b;
  endfunction

  task automatic push_beat(input logic [OP_W-1:0] op, input logic flash, input logic [31:0] ms,
                           input logic done, input logic [3:0] slot, input logic [15:0] secs);
    beat_t b;
    b.op = op;
    b.flash = flash;
    b.ms = ms;
    b.done = done;
    b.slot = slot;
    b.secs = secs;
    pending_beats.push_back(b);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TRANSITION: cfg_fade_len = val;
      REG_FULL:       cfg_full = val[7:0];
      REG_SEGMENTS:   cfg_segments = val[4:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] fade_len, input logic [7:0] full,
                                input logic [4:0] segments);
    wait_drained();
    write_register(REG_TRANSITION, fade_len);
    write_register(REG_FULL, CFG_W'(full));
    write_register(REG_SEGMENTS, CFG_W'(segments));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    beat_t b;
    int unsigned pick;
    logic [15:0] fade_pick;
    logic [7:0]  full_pick;
    logic [4:0]  seg_pick;

    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      slot_secs[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF);
    push_beat(OP_START, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_STOP, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b1, '0, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b0, 32'hFFFF_FFFF, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b1, '0, '0);
    push_beat(OP_LOAD, 1'b0, '0, 1'b0, 4'd0, 16'd0);
    push_beat(OP_LOAD, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF);

    apply_settings(16'd0, 8'd0, 5'd2);
    push_beat(OP_START, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b1, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b0, 32'd0, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_LOAD, 1'b0, '0, 1'b0, 4'd1, 16'd0);
    push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_STOP, 1'b0, '0, 1'b0, '0, '0);

    apply_settings(16'd3, 8'd200, 5'd31);
    push_beat(OP_START, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b0, 32'd2, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b1, '0, 1'b0, '0, '0);
    for (int i = 0; i < 9; i++) push_beat(OP_TICK, 1'b0, '0, 1'b0, '0, '0);

    // long segment: one second of ticks with short interrupts that freeze its clock
    apply_settings(16'd2, 8'd255, 5'd2);
    push_beat(OP_LOAD, 1'b0, '0, 1'b0, 4'd0, 16'd1);
    push_beat(OP_LOAD, 1'b0, '0, 1'b0, 4'd1, 16'd0);
    push_beat(OP_START, 1'b0, '0, 1'b0, '0, '0);
    for (int i = 0; i < 1100; i++) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        b = noise_beat(OP_TRIG);
        b.ms = $urandom_range(0, 6);
      end else begin
        b = noise_beat(OP_TICK);
        b.done = ($urandom_range(0, 3) == 0);
      end
      pending_beats.push_back(b);
    end

    for (int ph = 0; ph < 9; ph++) begin
      pick = $urandom_range(0, 99);
      if (ph == 1) fade_pick = 16'hFFFF;
      else if (pick < 20) fade_pick = 16'd0;
      else if (pick < 60) fade_pick = 16'($urandom_range(1, 8));
      else if (pick < 80) fade_pick = 16'($urandom_range(9, 40));
      else if (pick < 88) fade_pick = 16'hFFFF;
      else fade_pick = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (ph == 1 || pick < 20) full_pick = 8'd255;
      else if (pick < 40) full_pick = 8'd0;
      else full_pick = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (ph == 1) seg_pick = 5'd16;
      else if (pick < 10) seg_pick = 5'd0;
      else if (pick < 25) seg_pick = 5'($urandom_range(17, 31));
      else if (pick < 35) seg_pick = 5'd16;
      else seg_pick = 5'($urandom_range(1, 4));
      apply_settings(fade_pick, full_pick, seg_pick);

      for (int i = 0; i < 110; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          b = noise_beat(OP_TICK);
          b.done = ($urandom_range(0, 3) == 0);
        end else if (pick < 72) begin
          b = noise_beat(OP_LOAD);
          if ($urandom_range(0, 9) < 8) b.secs = '0;
        end else if (pick < 82) begin
          b = noise_beat(OP_TRIG);
          b.ms = ($urandom_range(0, 4) < 4) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        end else if (pick < 92) begin
          b = noise_beat(OP_START);
        end else begin
          b = noise_beat(OP_STOP);
        end
        pending_beats.push_back(b);
      end
    end

    // long active interrupt last, since only reset or the ticks reaching its huge limit would end it
    apply_settings(16'd1, 8'd255, 5'd1);
    push_beat(OP_LOAD, 1'b0, '0, 1'b0, 4'd0, 16'd0);
    push_beat(OP_START, 1'b0, '0, 1'b0, '0, '0);
    push_beat(OP_TRIG, 1'b0, {1'b1, 31'($urandom)}, 1'b0, '0, '0);
    for (int i = 0; i < 6; i++) begin
      b = noise_beat(OP_TICK);
      pending_beats.push_back(b);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
